### rtl/integer_alu_with_compare_assert.svh
// Assertion macros for the integer ALU.
// Included by the top-level RTL file, which checks its own pipeline behavior.
`ifndef INTEGER_ALU_WITH_COMPARE_ASSERT_SVH
`define INTEGER_ALU_WITH_COMPARE_ASSERT_SVH

// Condition holds at every edge outside reset.
`define IALU_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define IALU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Condition holds in the cycle after reset is sampled high.
`define IALU_ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("assertion failed after reset");

`endif

### rtl/ialu_pkg.sv
// Shared opcodes, status codes and sideband type for the integer ALU.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ialu_pkg;

   localparam logic [7:0] OPC_MUL = 8'h08;
   localparam logic [7:0] OPC_DIV = 8'h09;
   localparam logic [7:0] OPC_REM = 8'h0a;
   localparam logic [7:0] OPC_MOD = 8'h0b;
   localparam logic [7:0] OPC_ADD = 8'h0c;
   localparam logic [7:0] OPC_SUB = 8'h0d;
   localparam logic [7:0] OPC_AND = 8'h0e;
   localparam logic [7:0] OPC_OR  = 8'h0f;
   localparam logic [7:0] OPC_XOR = 8'h10;
   localparam logic [7:0] OPC_SHL = 8'h13;
   localparam logic [7:0] OPC_SHR = 8'h14;
   localparam logic [7:0] OPC_CMP = 8'h15;

   localparam logic [2:0] CMP_LT = 3'd1;
   localparam logic [2:0] CMP_LE = 3'd2;
   localparam logic [2:0] CMP_EQ = 3'd3;
   localparam logic [2:0] CMP_NE = 3'd4;
   localparam logic [2:0] CMP_GE = 3'd5;
   localparam logic [2:0] CMP_GT = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIV0  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;
   localparam logic [1:0] ST_UNSUP = 2'd3;

   localparam logic [63:0] SHIFT_LIMIT = 64'd63;
   localparam int DIV_STEPS = 64;

   typedef struct packed {
      logic [7:0]  op;
      logic [1:0]  status;
      logic [63:0] value;
      logic [63:0] b;
      logic        neg_q;
      logic        neg_r;
   } side_type;

endpackage
`default_nettype wire

### rtl/ialu_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ialu_pkg for the sideband type and stage count.
`timescale 1ns / 1ps
`default_nettype none
module ialu_div_pipe (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [63:0]          in_dividend,
   input  wire logic [63:0]          in_divisor,
   input  wire ialu_pkg::side_type   in_side,
   output logic                      out_valid,
   output logic [63:0]               out_quot,
   output logic [63:0]               out_rem,
   output ialu_pkg::side_type        out_side
);
   import ialu_pkg::*;

   logic [DIV_STEPS-1:0] valid_ff;
   logic [63:0]          rem_ff  [DIV_STEPS];
   logic [63:0]          quo_ff  [DIV_STEPS];
   logic [63:0]          dvs_ff  [DIV_STEPS];
   side_type             side_ff [DIV_STEPS];

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic        valid_prev;
      logic [63:0] rem_prev;
      logic [63:0] quo_prev;
      logic [63:0] dvs_prev;
      side_type    side_prev;
      logic [63:0] shifted;
      logic        ge;
      logic [63:0] rem_in;
      logic [63:0] quo_in;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign quo_prev   = in_dividend;
         assign dvs_prev   = in_divisor;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign quo_prev   = quo_ff[s-1];
         assign dvs_prev   = dvs_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      assign shifted = {rem_prev[62:0], quo_prev[63]};
      assign ge      = shifted >= dvs_prev;
      assign rem_in  = ge ? (shifted - dvs_prev) : shifted;
      assign quo_in  = {quo_prev[62:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_prev;
         end
         if (en) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            dvs_ff[s]  <= dvs_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_quot  = quo_ff[DIV_STEPS-1];
   assign out_rem   = rem_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

endmodule
`default_nettype wire

### rtl/integer_alu_with_compare.sv
// Top level of the 64-bit integer ALU with compare.
// Depends on ialu_pkg, ialu_div_pipe and the assertion macro header.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | op, cmp_kind, operand_a, operand_b
//   rsp     | out       | rsp_valid/rsp_ready | value_out, status
//
// Every opcode passes through every stage; one transfer per cycle while the result is not stalled.
// The depth is set by the divider, one quotient bit per stage.
// Reset clears all stage valid bits.
// A stalled result freezes every stage; req_ready drops with it.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_alu_with_compare_assert.svh"
module integer_alu_with_compare (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_op,
   input  wire logic [2:0]  req_cmp_kind,
   input  wire logic [63:0] req_operand_a,
   input  wire logic [63:0] req_operand_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_value_out,
   output logic [1:0]       rsp_status
);
   import ialu_pkg::*;

   logic en;

   // stage 0: input capture
   logic        s0_valid_ff;
   logic [7:0]  s0_op_ff;
   logic [2:0]  s0_kind_ff;
   logic [63:0] s0_a_ff;
   logic [63:0] s0_b_ff;

   // stage 1: decode, simple ops, partial products
   logic        s1_valid_ff;
   side_type    s1_side_ff, s1_side_in;
   logic [63:0] s1_mag_a_ff, s1_mag_a_in;
   logic [63:0] s1_mag_b_ff, s1_mag_b_in;
   logic [63:0] s1_p0_ff, s1_p0_in;
   logic [31:0] s1_p1_ff, s1_p1_in;
   logic [31:0] s1_p2_ff, s1_p2_in;

   // stage 2: product sum
   logic        s2_valid_ff;
   side_type    s2_side_ff, s2_side_in;
   logic [63:0] s2_mag_a_ff;
   logic [63:0] s2_mag_b_ff;

   logic        dv_valid;
   logic [63:0] dv_quot;
   logic [63:0] dv_rem;
   side_type    dv_side;

   // final stages: sign fix, then select
   logic        f1_valid_ff;
   side_type    f1_side_ff;
   logic [63:0] f1_quot_ff, f1_quot_in;
   logic [63:0] f1_rem_ff, f1_rem_in;

   logic        f2_valid_ff;
   logic [63:0] f2_value_ff, f2_value_in;
   logic [1:0]  f2_status_ff;
   logic [7:0]  f2_op_ff;

   assign en        = !f2_valid_ff || rsp_ready;
   assign req_ready = en;

   always_comb begin
      logic [63:0] a;
      logic [63:0] b;
      logic        bad_shift;
      logic        lt;
      logic        gt;
      a = s0_a_ff;
      b = s0_b_ff;
      bad_shift = b[63] || (b >= SHIFT_LIMIT);
      lt = $signed(a) < $signed(b);
      gt = $signed(b) < $signed(a);
      s1_side_in.op     = s0_op_ff;
      s1_side_in.b      = b;
      s1_side_in.neg_q  = a[63] ^ b[63];
      s1_side_in.neg_r  = a[63];
      s1_side_in.status = ST_OK;
      s1_side_in.value  = '0;
      case (s0_op_ff)
         OPC_MUL: s1_side_in.value = '0;
         OPC_ADD: s1_side_in.value = a + b;
         OPC_SUB: s1_side_in.value = a - b;
         OPC_AND: s1_side_in.value = a & b;
         OPC_OR:  s1_side_in.value = a | b;
         OPC_XOR: s1_side_in.value = a ^ b;
         OPC_DIV, OPC_REM, OPC_MOD: begin
            if (b == '0) s1_side_in.status = ST_DIV0;
         end
         OPC_SHL: begin
            if (bad_shift) s1_side_in.status = ST_SHIFT;
            else s1_side_in.value = a << b[5:0];
         end
         OPC_SHR: begin
            if (bad_shift) s1_side_in.status = ST_SHIFT;
            else s1_side_in.value = $unsigned($signed(a) >>> b[5:0]);
         end
         OPC_CMP: begin
            case (s0_kind_ff)
               CMP_LT:  s1_side_in.value = {63'd0, lt};
               CMP_LE:  s1_side_in.value = {63'd0, !gt};
               CMP_EQ:  s1_side_in.value = {63'd0, a == b};
               CMP_NE:  s1_side_in.value = {63'd0, a != b};
               CMP_GE:  s1_side_in.value = {63'd0, !lt};
               CMP_GT:  s1_side_in.value = {63'd0, gt};
               default: s1_side_in.status = ST_UNSUP;
            endcase
         end
         default: s1_side_in.status = ST_UNSUP;
      endcase
      s1_mag_a_in = a[63] ? (64'd0 - a) : a;
      s1_mag_b_in = b[63] ? (64'd0 - b) : b;
      s1_p0_in = {32'd0, a[31:0]} * {32'd0, b[31:0]};
      s1_p1_in = 32'(a[31:0] * b[63:32]);
      s1_p2_in = 32'(a[63:32] * b[31:0]);
   end

   always_comb begin
      s2_side_in = s1_side_ff;
      if (s1_side_ff.op == OPC_MUL) begin
         s2_side_in.value = s1_p0_ff + {s1_p1_ff + s1_p2_ff, 32'd0};
      end
   end

   ialu_div_pipe u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s2_valid_ff),
      .in_dividend (s2_mag_a_ff),
      .in_divisor  (s2_mag_b_ff),
      .in_side     (s2_side_ff),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_rem     (dv_rem),
      .out_side    (dv_side)
   );

   assign f1_quot_in = dv_side.neg_q ? (64'd0 - dv_quot) : dv_quot;
   assign f1_rem_in  = dv_side.neg_r ? (64'd0 - dv_rem) : dv_rem;

   always_comb begin
      f2_value_in = f1_side_ff.value;
      case (f1_side_ff.op)
         OPC_DIV: f2_value_in = f1_quot_ff;
         OPC_REM: f2_value_in = f1_rem_ff;
         OPC_MOD: begin
            if (f1_rem_ff != '0 && (f1_rem_ff[63] != f1_side_ff.b[63]))
               f2_value_in = f1_rem_ff + f1_side_ff.b;
            else
               f2_value_in = f1_rem_ff;
         end
         default: f2_value_in = f1_side_ff.value;
      endcase
      if (f1_side_ff.status != ST_OK) f2_value_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         f1_valid_ff <= dv_valid;
         f2_valid_ff <= f1_valid_ff;
      end
      if (en) begin
         s0_op_ff     <= req_op;
         s0_kind_ff   <= req_cmp_kind;
         s0_a_ff      <= req_operand_a;
         s0_b_ff      <= req_operand_b;
         s1_side_ff   <= s1_side_in;
         s1_mag_a_ff  <= s1_mag_a_in;
         s1_mag_b_ff  <= s1_mag_b_in;
         s1_p0_ff     <= s1_p0_in;
         s1_p1_ff     <= s1_p1_in;
         s1_p2_ff     <= s1_p2_in;
         s2_side_ff   <= s2_side_in;
         s2_mag_a_ff  <= s1_mag_a_ff;
         s2_mag_b_ff  <= s1_mag_b_ff;
         f1_side_ff   <= dv_side;
         f1_quot_ff   <= f1_quot_in;
         f1_rem_ff    <= f1_rem_in;
         f2_value_ff  <= f2_value_in;
         f2_status_ff <= f1_side_ff.status;
         f2_op_ff     <= f1_side_ff.op;
      end
   end

   assign rsp_valid     = f2_valid_ff;
   assign rsp_value_out = f2_value_ff;
   assign rsp_status    = f2_status_ff;

   `IALU_ASSERT_ALWAYS(a_error_zero, !(rsp_valid && rsp_status != ST_OK) || rsp_value_out == '0)
   `IALU_ASSERT_ALWAYS(a_cmp_bool,
      !(rsp_valid && f2_op_ff == OPC_CMP && rsp_status == ST_OK) || rsp_value_out[63:1] == '0)
   `IALU_ASSERT_NEXT(a_stall_freeze, f1_valid_ff && !en, f1_valid_ff && $stable(f1_rem_ff))
   `IALU_ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid && !f1_valid_ff && !s0_valid_ff)

endmodule
`default_nettype wire
